### sv/two_class_fifo_oldest_first_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-class FIFO unit.
// Shared immediate-implication and next-cycle property forms.
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TCF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Antecedent implies consequent in the following cycle.
`define TCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

### sv/tcf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcf_pkg
// Types, codes and defaults shared by the two-class FIFO unit.
// ---------------------------------------------------------------------------
package tcf_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int TAG_WIDTH_DEF = 16;

	localparam int OPCODE_W = 2;
	localparam int KIND_W   = 2;
	localparam int TAG_IO_W = 16;
	localparam int STATUS_W = 3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_ENQ     = 2'd0,
		OP_DEQ_ANY = 2'd1,
		OP_DEQ0    = 2'd2,
		OP_DEQ1    = 2'd3
	} op_t;

	localparam logic [KIND_W-1:0] KIND_C0 = 2'd0;
	localparam logic [KIND_W-1:0] KIND_C1 = 2'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ENQ     = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_FULL    = 3'd2,
		ST_DEQ     = 3'd3,
		ST_NONE    = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

### sv/tcf_fifo.sv
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_unit_macros.svh"
// ---------------------------------------------------------------------------
// tcf_fifo
// One class queue: entry memory, head and tail pointers, fill count.
// ---------------------------------------------------------------------------
module tcf_fifo #(
	parameter int DEPTH       = tcf_pkg::DEPTH_DEF,
	parameter int TAG_WIDTH   = tcf_pkg::TAG_WIDTH_DEF,
	parameter int STAMP_WIDTH = $clog2(tcf_pkg::DEPTH_DEF) + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic                   pop,
	input  logic [TAG_WIDTH-1:0]   wr_tag,
	input  logic [STAMP_WIDTH-1:0] wr_stamp,
	output logic [TAG_WIDTH-1:0]   head_tag,
	output logic [STAMP_WIDTH-1:0] head_stamp,
	output logic                   empty,
	output logic                   full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = TAG_WIDTH + STAMP_WIDTH;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= {wr_tag, wr_stamp};
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == AW'(DEPTH - 1)) ? '0 : tail_q + AW'(1);
			end
			if (pop) begin
				head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	assign head_tag   = rd_q[EW-1:STAMP_WIDTH];
	assign head_stamp = rd_q[STAMP_WIDTH-1:0];
	assign empty      = (cnt_q == '0);
	assign full       = (cnt_q == CW'(DEPTH));

	`TCF_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`TCF_ASSERT_SAME(a_no_push_full, clk, arst_n, push, !full && !pop)
	`TCF_ASSERT_NEXT(a_pop_drops, clk, arst_n, pop && !empty, cnt_q == $past(cnt_q) - CW'(1))

endmodule

### sv/tcf_ctrl.sv
`timescale 1ns / 1ps
`include "two_class_fifo_oldest_first_unit_macros.svh"
// ---------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: takes a command, runs the execute cycle, strobes the result.
// ---------------------------------------------------------------------------
module tcf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output tcf_pkg::cmd_t cmd
);

	import tcf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);

	`TCF_ASSERT_NEXT(a_load_exec, clk, arst_n, cmd.load, cmd.exec)
	`TCF_ASSERT_NEXT(a_exec_done, clk, arst_n, cmd.exec, done && !busy)
	`TCF_ASSERT_SAME(a_done_idle, clk, arst_n, done, !cmd.exec)

endmodule

### sv/tcf_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcf_dp
// Datapath: command latch, both class queues, arrival stamp, result registers.
// ---------------------------------------------------------------------------
module tcf_dp #(
	parameter int DEPTH     = tcf_pkg::DEPTH_DEF,
	parameter int TAG_WIDTH = tcf_pkg::TAG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcf_pkg::cmd_t                 cmd,
	input  logic [tcf_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tcf_pkg::KIND_W-1:0]    kind,
	input  logic [tcf_pkg::TAG_IO_W-1:0]  tag_in,
	output logic [tcf_pkg::TAG_IO_W-1:0]  tag_out,
	output logic                          kind_out,
	output logic [tcf_pkg::STATUS_W-1:0]  status
);

	import tcf_pkg::*;

	localparam int SW = $clog2(DEPTH) + 2;

	op_t                 op_q;
	logic [KIND_W-1:0]   kind_q;
	logic [TAG_IO_W-1:0] tag_q;
	logic [SW-1:0]       stamp_q;

	logic [TAG_WIDTH-1:0] head_tag0, head_tag1;
	logic [SW-1:0]        head_stamp0, head_stamp1;
	logic                 empty0, empty1, full0, full1;
	logic                 push0, push1, pop0, pop1;
	logic [SW-1:0]        stamp_diff;
	logic                 older0;
	logic                 take0;

	logic [TAG_IO_W-1:0] res_tag;
	logic                res_kind;
	status_t             res_st;

	logic [TAG_IO_W-1:0] tag_out_q;
	logic                kind_out_q;
	status_t             status_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(opcode);
			kind_q <= kind;
			tag_q  <= tag_in;
		end
		if (cmd.exec) begin
			tag_out_q  <= res_tag;
			kind_out_q <= res_kind;
			status_q   <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q <= '0;
		end else if (push0 || push1) begin
			stamp_q <= stamp_q + SW'(1);
		end
	end

	tcf_fifo #(
		.DEPTH       (DEPTH),
		.TAG_WIDTH   (TAG_WIDTH),
		.STAMP_WIDTH (SW)
	) u_fifo0 (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push0),
		.pop        (pop0),
		.wr_tag     (TAG_WIDTH'(tag_q)),
		.wr_stamp   (stamp_q),
		.head_tag   (head_tag0),
		.head_stamp (head_stamp0),
		.empty      (empty0),
		.full       (full0)
	);

	tcf_fifo #(
		.DEPTH       (DEPTH),
		.TAG_WIDTH   (TAG_WIDTH),
		.STAMP_WIDTH (SW)
	) u_fifo1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push1),
		.pop        (pop1),
		.wr_tag     (TAG_WIDTH'(tag_q)),
		.wr_stamp   (stamp_q),
		.head_tag   (head_tag1),
		.head_stamp (head_stamp1),
		.empty      (empty1),
		.full       (full1)
	);

	// Class 0 is older when the stamp distance lies in the lower half, excluding zero.
	assign stamp_diff = head_stamp1 - head_stamp0;
	assign older0     = (stamp_diff != '0) && !stamp_diff[SW-1];

	always_comb begin
		push0    = 1'b0;
		push1    = 1'b0;
		pop0     = 1'b0;
		pop1     = 1'b0;
		take0    = 1'b0;
		res_tag  = '0;
		res_kind = 1'b0;
		res_st   = ST_NONE;
		case (op_q)
			OP_ENQ: begin
				if (kind_q == KIND_C0) begin
					res_st = full0 ? ST_FULL : ST_ENQ;
					push0  = cmd.exec && !full0;
				end else if (kind_q == KIND_C1) begin
					res_st = full1 ? ST_FULL : ST_ENQ;
					push1  = cmd.exec && !full1;
				end else begin
					res_st = ST_UNKNOWN;
				end
			end
			OP_DEQ_ANY, OP_DEQ0, OP_DEQ1: begin
				if (op_q == OP_DEQ_ANY) begin
					take0 = empty1 ? 1'b1 : (empty0 ? 1'b0 : older0);
				end else begin
					take0 = (op_q == OP_DEQ0);
				end
				if (take0 && !empty0) begin
					res_st  = ST_DEQ;
					res_tag = TAG_IO_W'(head_tag0);
					pop0    = cmd.exec;
				end else if (!take0 && !empty1) begin
					res_st   = ST_DEQ;
					res_tag  = TAG_IO_W'(head_tag1);
					res_kind = 1'b1;
					pop1     = cmd.exec;
				end
			end
			default: begin
				res_st = ST_NONE;
			end
		endcase
	end

	assign tag_out  = tag_out_q;
	assign kind_out = kind_out_q;
	assign status   = status_q;

endmodule

### sv/two_class_fifo_oldest_first_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// two_class_fifo_oldest_first_unit
// Two class queues with arrival stamps; dequeue by class or oldest first.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  command   in         start / busy   opcode, kind, tag_in
//  result    out        done           tag_out, kind_out, status
//
// Each command runs through an accept cycle, in which the registered
// head reads of both entry memories settle, and an execute cycle.
// A new command can be accepted in the cycle in which done is high.
// Reset clears pointers, counts and the arrival stamp; the entry memories
// are not cleared and the head of an empty queue is never used.
// The receiver cannot stall; done is high for exactly one cycle per beat.
// ---------------------------------------------------------------------------
module two_class_fifo_oldest_first_unit #(
	parameter int DEPTH     = tcf_pkg::DEPTH_DEF,
	parameter int TAG_WIDTH = tcf_pkg::TAG_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tcf_pkg::OPCODE_W-1:0]  opcode,
	input  logic [tcf_pkg::KIND_W-1:0]    kind,
	input  logic [tcf_pkg::TAG_IO_W-1:0]  tag_in,
	output logic                          done,
	output logic [tcf_pkg::TAG_IO_W-1:0]  tag_out,
	output logic                          kind_out,
	output logic [tcf_pkg::STATUS_W-1:0]  status
);

	import tcf_pkg::*;

	cmd_t cmd;

	tcf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	tcf_dp #(
		.DEPTH     (DEPTH),
		.TAG_WIDTH (TAG_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.opcode   (opcode),
		.kind     (kind),
		.tag_in   (tag_in),
		.tag_out  (tag_out),
		.kind_out (kind_out),
		.status   (status)
	);

endmodule
